>>> rtl/nhpi_pkg.sv
// Package for the Nose-Hoover particle integrator.
// Holds the payload, configuration and divider types, the number format and the helpers.
// No dependencies.
package nhpi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_NUM_W = 56;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam logic [2:0] CFG_TIME_STEP = 3'd0;
  localparam logic [2:0] CFG_GAIN      = 3'd1;
  localparam logic [2:0] CFG_TEMP_TGT  = 3'd2;
  localparam logic [2:0] CFG_DOF       = 3'd3;
  localparam logic [2:0] CFG_BOX_X     = 3'd4;
  localparam logic [2:0] CFG_BOX_Y     = 3'd5;
  localparam logic [2:0] CFG_BOX_Z     = 3'd6;

  typedef struct packed {
    logic               func;
    logic               last_item;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_or_force_x;
    logic signed [31:0] acc_or_force_y;
    logic signed [31:0] acc_or_force_z;
    logic        [30:0] mass;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_acc_x;
    logic signed [31:0] new_acc_y;
    logic signed [31:0] new_acc_z;
    logic        [5:0]  wrap_code;
    logic        [30:0] kinetic_temp;
  } out_item_t;

  typedef struct packed {
    logic [30:0] time_step;
    logic [30:0] thermostat_gain;
    logic [30:0] temp_target;
    logic [15:0] dof_count;
    logic [63:0] box_x_bounds;
    logic [63:0] box_y_bounds;
    logic [63:0] box_z_bounds;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_D_MUL, ST_D_POST, ST_R_WAIT,
    ST_H_MUL, ST_H_POST, ST_V_MUL, ST_V_POST,
    ST_P_MUL, ST_P_POST, ST_S_MUL, ST_S_POST,
    ST_K_MUL, ST_K_POST,
    ST_T_START, ST_T_WAIT, ST_E_START, ST_E_WAIT,
    ST_X_MUL, ST_X_POST, ST_Y_MUL, ST_Y_POST,
    ST_A_START, ST_A_WAIT, ST_F_MUL, ST_F_POST, ST_G_MUL, ST_G_POST,
    ST_DONE
  } back_state_e;

  function automatic logic signed [31:0] sat32(input logic signed [69:0] x);
    logic signed [31:0] r;
    if (x > 70'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -70'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/nhpi_front.sv
// Front end of the integrator: input transfer and a short item queue.
// Depends on nhpi_pkg.
module nhpi_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  nhpi_pkg::in_item_t in_data_i,
  output nhpi_pkg::queue_head_t head_o,
  input  logic              pop_i
);
  import nhpi_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  in_item_t         mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign in_stall_o = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign push = in_valid_i && !in_stall_o;
  assign pop = pop_i && (cnt_q != '0);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

>>> rtl/nhpi_div.sv
// Bit-serial signed divider, one quotient bit per cycle, quotient truncated toward zero.
// Depends on nhpi_pkg.
module nhpi_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nhpi_pkg::div_req_t req_i,
  output nhpi_pkg::div_rsp_t rsp_o
);
  import nhpi_pkg::*;

  logic [64:0]          rem_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [63:0]          den_q;
  logic                 neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [64:0]          trial;
  logic                 fits;

  assign trial = {rem_q[63:0], quo_q[DIV_NUM_W-1]};
  assign fits = (trial >= {1'b0, den_q});
  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? -$signed(64'(quo_q)) : $signed(64'(quo_q));

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num[63] ? DIV_NUM_W'(-req_i.num) : DIV_NUM_W'(req_i.num);
      den_q <= req_i.den[63] ? 64'(-req_i.den) : 64'(req_i.den);
      neg_q <= req_i.num[63] ^ req_i.den[63];
    end else if (busy_q) begin
      rem_q <= fits ? trial - {1'b0, den_q} : trial;
      quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

>>> rtl/nhpi_back.sv
// Back end of the integrator: sequencer around one shared multiplier and the divider,
// thermostat state and the output register. Depends on nhpi_pkg and nhpi_div.
module nhpi_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nhpi_pkg::cfg_t        cfg_i,
  input  nhpi_pkg::queue_head_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output nhpi_pkg::out_item_t   out_data_o
);
  import nhpi_pkg::*;

  localparam logic signed [69:0] ONE_W = 70'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] ONE_SQ = 64'sd1 <<< (2 * FRAC_BITS);
  localparam logic [49:0] SUM_MAX = 50'h0_FFFF_FFFF_FFFF;
  localparam logic [49:0] SPEED_MAX = 50'h0_0000_FFFF_FFFF;

  back_state_e st_q, st_d;
  in_item_t    item_q;
  logic [1:0]  k_q;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_q;
  logic signed [31:0] recip_q, hk_q, d_q, err_q, xi_q, eta_q;
  logic signed [32:0] xsum_q;
  logic signed [31:0] nvel_q [3];
  logic signed [31:0] npos_q [3];
  logic signed [31:0] nacc_q [3];
  logic [5:0]         wrap_q;
  logic [49:0]        speed_q;
  logic [47:0]        sum_q;
  logic [30:0]        temp_q, cur_temp_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic signed [31:0] pos_a [3];
  logic signed [31:0] vel_a [3];
  logic signed [31:0] af_a [3];
  logic [63:0]        box_a [3];
  logic signed [33:0] dt_s;
  logic signed [69:0] denom, pw, hi_w, lo_w, len_w;
  logic [49:0]        ksum;
  logic signed [31:0] xi_new;
  logic [15:0]        dof_eff;
  logic [30:0]        tgt_eff;
  logic               load_out;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  nhpi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign pos_a[0] = item_q.pos_x;
  assign pos_a[1] = item_q.pos_y;
  assign pos_a[2] = item_q.pos_z;
  assign vel_a[0] = item_q.vel_x;
  assign vel_a[1] = item_q.vel_y;
  assign vel_a[2] = item_q.vel_z;
  assign af_a[0] = item_q.acc_or_force_x;
  assign af_a[1] = item_q.acc_or_force_y;
  assign af_a[2] = item_q.acc_or_force_z;
  assign box_a[0] = cfg_i.box_x_bounds;
  assign box_a[1] = cfg_i.box_y_bounds;
  assign box_a[2] = cfg_i.box_z_bounds;

  assign dt_s = $signed({3'b000, cfg_i.time_step});
  assign dof_eff = (cfg_i.dof_count == '0) ? 16'd1 : cfg_i.dof_count;
  assign tgt_eff = (cfg_i.temp_target == '0) ? 31'd1 : cfg_i.temp_target;

  assign denom = ONE_W + 70'(prod_q >>> (FRAC_BITS + 1));
  assign hi_w = 70'($signed(box_a[k_q][31:0]));
  assign lo_w = 70'($signed(box_a[k_q][63:32]));
  assign len_w = hi_w - lo_w;
  assign pw = 70'(pos_a[k_q]) + 70'(prod_q >>> FRAC_BITS);
  assign ksum = {2'b00, sum_q} + 50'(prod_q >>> FRAC_BITS);
  assign xi_new = sat32(70'(xi_q) + 70'(prod_q >>> FRAC_BITS));

  assign load_out = (st_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign pop_o = (st_q == ST_IDLE) && head_i.valid;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  always_comb begin
    mul_a = dt_s;
    mul_b = 34'(xi_q);
    case (st_q)
      ST_H_MUL: begin mul_a = 34'(af_a[k_q]); mul_b = dt_s; end
      ST_V_MUL: begin mul_a = 34'(hk_q); mul_b = 34'(recip_q); end
      ST_P_MUL: begin mul_a = dt_s; mul_b = 34'(nvel_q[k_q]); end
      ST_S_MUL: begin mul_a = 34'(nvel_q[k_q]); mul_b = 34'(nvel_q[k_q]); end
      ST_K_MUL: begin
        mul_a = (speed_q > SPEED_MAX) ? $signed(34'(SPEED_MAX)) : $signed(34'(speed_q));
        mul_b = $signed({3'b000, item_q.mass});
      end
      ST_X_MUL: begin mul_a = $signed({3'b000, cfg_i.thermostat_gain}); mul_b = 34'(err_q); end
      ST_Y_MUL: begin mul_a = dt_s; mul_b = 34'(xsum_q); end
      ST_F_MUL: begin mul_a = 34'(xi_q); mul_b = 34'(vel_a[k_q]); end
      ST_G_MUL: begin mul_a = dt_s; mul_b = 34'(d_q); end
      default: begin mul_a = dt_s; mul_b = 34'(xi_q); end
    endcase
  end

  always_comb begin
    st_d = st_q;
    div_req.start = 1'b0;
    div_req.num = ONE_SQ;
    div_req.den = 64'(denom);
    case (st_q)
      ST_IDLE: if (head_i.valid) st_d = head_i.item.func ? ST_A_START : ST_D_MUL;
      ST_D_MUL: st_d = ST_D_POST;
      ST_D_POST: begin
        if (denom == '0) begin
          st_d = ST_H_MUL;
        end else begin
          div_req.start = 1'b1;
          st_d = ST_R_WAIT;
        end
      end
      ST_R_WAIT: if (div_rsp.done) st_d = ST_H_MUL;
      ST_H_MUL: st_d = ST_H_POST;
      ST_H_POST: st_d = ST_V_MUL;
      ST_V_MUL: st_d = ST_V_POST;
      ST_V_POST: st_d = ST_P_MUL;
      ST_P_MUL: st_d = ST_P_POST;
      ST_P_POST: st_d = ST_S_MUL;
      ST_S_MUL: st_d = ST_S_POST;
      ST_S_POST: st_d = (k_q == 2'd2) ? ST_K_MUL : ST_H_MUL;
      ST_K_MUL: st_d = ST_K_POST;
      ST_K_POST: st_d = item_q.last_item ? ST_T_START : ST_DONE;
      ST_T_START: begin
        div_req.start = 1'b1;
        div_req.num = 64'(sum_q);
        div_req.den = 64'(dof_eff);
        st_d = ST_T_WAIT;
      end
      ST_T_WAIT: if (div_rsp.done) st_d = ST_E_START;
      ST_E_START: begin
        div_req.start = 1'b1;
        div_req.num = 64'(temp_q) << FRAC_BITS;
        div_req.den = 64'(tgt_eff);
        st_d = ST_E_WAIT;
      end
      ST_E_WAIT: if (div_rsp.done) st_d = ST_X_MUL;
      ST_X_MUL: st_d = ST_X_POST;
      ST_X_POST: st_d = ST_Y_MUL;
      ST_Y_MUL: st_d = ST_Y_POST;
      ST_Y_POST: st_d = ST_DONE;
      ST_A_START: begin
        if (item_q.mass == '0) begin
          st_d = ST_F_MUL;
        end else begin
          div_req.start = 1'b1;
          div_req.num = 64'(af_a[k_q]) <<< FRAC_BITS;
          div_req.den = 64'(item_q.mass);
          st_d = ST_A_WAIT;
        end
      end
      ST_A_WAIT: if (div_rsp.done) st_d = ST_F_MUL;
      ST_F_MUL: st_d = ST_F_POST;
      ST_F_POST: st_d = ST_G_MUL;
      ST_G_MUL: st_d = ST_G_POST;
      ST_G_POST: st_d = (k_q == 2'd2) ? ST_DONE : ST_A_START;
      ST_DONE: if (load_out) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (load_out) begin
      out_q.new_pos_x <= npos_q[0];
      out_q.new_pos_y <= npos_q[1];
      out_q.new_pos_z <= npos_q[2];
      out_q.new_vel_x <= nvel_q[0];
      out_q.new_vel_y <= nvel_q[1];
      out_q.new_vel_z <= nvel_q[2];
      out_q.new_acc_x <= nacc_q[0];
      out_q.new_acc_y <= nacc_q[1];
      out_q.new_acc_z <= nacc_q[2];
      out_q.wrap_code <= wrap_q;
      out_q.kinetic_temp <= cur_temp_q;
    end
    case (st_q)
      ST_IDLE: begin
        item_q <= head_i.item;
        k_q <= 2'd0;
        wrap_q <= '0;
        speed_q <= '0;
      end
      ST_D_POST: if (denom == '0) recip_q <= 32'sh7FFF_FFFF;
      ST_R_WAIT: if (div_rsp.done) recip_q <= sat32(70'(div_rsp.quot));
      ST_H_POST: hk_q <= sat32(70'(vel_a[k_q]) + 70'(prod_q >>> (FRAC_BITS + 1)));
      ST_V_POST: nvel_q[k_q] <= sat32(70'(prod_q >>> FRAC_BITS));
      ST_P_POST: begin
        if (pw >= hi_w) begin
          npos_q[k_q] <= sat32(pw - len_w);
          wrap_q[2*k_q +: 2] <= 2'd1;
        end else if (pw < lo_w) begin
          npos_q[k_q] <= sat32(pw + len_w);
          wrap_q[2*k_q +: 2] <= 2'd2;
        end else begin
          npos_q[k_q] <= sat32(pw);
        end
      end
      ST_S_POST: begin
        speed_q <= speed_q + 50'(prod_q >>> FRAC_BITS);
        nacc_q[k_q] <= af_a[k_q];
        k_q <= k_q + 2'd1;
      end
      ST_T_WAIT: begin
        if (div_rsp.done) begin
          temp_q <= (div_rsp.quot > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : div_rsp.quot[30:0];
        end
      end
      ST_E_WAIT: if (div_rsp.done) err_q <= sat32(70'(div_rsp.quot) - ONE_W);
      ST_X_POST: xsum_q <= 33'(xi_new) + 33'(xi_q);
      ST_A_START: begin
        if (item_q.mass == '0) begin
          if (af_a[k_q] > 0) begin
            nacc_q[k_q] <= 32'sh7FFF_FFFF;
          end else if (af_a[k_q] < 0) begin
            nacc_q[k_q] <= 32'sh8000_0000;
          end else begin
            nacc_q[k_q] <= '0;
          end
        end
      end
      ST_A_WAIT: if (div_rsp.done) nacc_q[k_q] <= sat32(70'(div_rsp.quot));
      ST_F_POST: d_q <= sat32(70'(nacc_q[k_q]) - 70'(prod_q >>> FRAC_BITS));
      ST_G_POST: begin
        nvel_q[k_q] <= sat32(70'(vel_a[k_q]) + 70'(prod_q >>> (FRAC_BITS + 1)));
        npos_q[k_q] <= pos_a[k_q];
        k_q <= k_q + 2'd1;
      end
      default: ;
    endcase
  end

  // thermostat state and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xi_q <= 32'(ONE_W);
      eta_q <= 32'(ONE_W);
      sum_q <= '0;
      cur_temp_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_K_POST: sum_q <= (ksum > SUM_MAX) ? SUM_MAX[47:0] : ksum[47:0];
        ST_T_WAIT: begin
          if (div_rsp.done) begin
            cur_temp_q <= (div_rsp.quot > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF
                                                          : div_rsp.quot[30:0];
          end
        end
        ST_X_POST: xi_q <= xi_new;
        ST_Y_POST: begin
          eta_q <= sat32(70'(eta_q) + 70'(prod_q >>> (FRAC_BITS + 1)));
          sum_q <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/nose_hoover_particle_integrator_unit.sv
// Nose-Hoover thermostatted velocity-Verlet integrator, one particle per transfer, Q16.16.
// An item runs through the sequencer in drift mode (func 0), skipping the division when the friction
// denominator is zero, or in kick mode (func 1), skipping the divisions with zero mass. The last
// drift-mode item of a pass adds the thermostat update. Divisions run on the bit-serial divider:
// one in drift mode, two more at pass end, three in kick mode. Every multiply uses a MUL and a POST
// state on the single shared multiplier, and the result is registered in the output register when the
// sequencer finishes. Two items queue ahead of the sequencer and one result waits in the output
// register; a stalled result holds the sequencer. Depends on nhpi_pkg, nhpi_front and nhpi_back.
module nose_hoover_particle_integrator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  nhpi_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nhpi_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);
  import nhpi_pkg::*;

  cfg_t        cfg_q;
  queue_head_t head;
  logic        pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step <= 31'd328;
      cfg_q.thermostat_gain <= 31'd65536;
      cfg_q.temp_target <= 31'd65536;
      cfg_q.dof_count <= 16'd1;
      cfg_q.box_x_bounds <= '0;
      cfg_q.box_y_bounds <= '0;
      cfg_q.box_z_bounds <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TIME_STEP: cfg_q.time_step <= cfg_data_i[30:0];
        CFG_GAIN:      cfg_q.thermostat_gain <= cfg_data_i[30:0];
        CFG_TEMP_TGT:  cfg_q.temp_target <= cfg_data_i[30:0];
        CFG_DOF:       cfg_q.dof_count <= cfg_data_i[15:0];
        CFG_BOX_X:     cfg_q.box_x_bounds <= cfg_data_i;
        CFG_BOX_Y:     cfg_q.box_y_bounds <= cfg_data_i;
        CFG_BOX_Z:     cfg_q.box_z_bounds <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nhpi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  nhpi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
